// ===== sv/tks_pkg.sv =====
`default_nettype none
package tks_pkg;

  localparam int TABLE_SIZE = 10;
  localparam int RANK_W     = 7;
  localparam int READ_W     = 6;
  localparam int SCORE_W    = 32;
  localparam int STAMP_W    = 32;
  localparam int PLAYER_W   = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [SCORE_W-1:0]  new_score;
    logic [STAMP_W-1:0]  new_time;
    logic [PLAYER_W-1:0] new_player;
    logic [READ_W-1:0]   read_rank;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]   insert_rank;
    logic                entry_valid;
    logic [SCORE_W-1:0]  entry_score;
    logic [STAMP_W-1:0]  entry_time;
    logic [PLAYER_W-1:0] entry_player;
  } out_item_t;

  // One stored entry, as held by a cell and handed down the chain
  typedef struct packed {
    logic                vld;
    logic [SCORE_W-1:0]  score;
    logic [STAMP_W-1:0]  stamp;
    logic [PLAYER_W-1:0] player;
  } slot_t;

endpackage
`default_nettype wire

// ===== sv/tks_cell.sv =====
`default_nettype none
module tks_cell
  import tks_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  ins_en,
  input  wire slot_t new_slot,
  input  wire slot_t left_slot,
  input  wire logic  left_keep,
  output logic       keep,
  output logic       take_new,
  output slot_t      slot
);

  slot_t slot_r;
  slot_t slot_nxt;

  // Stay put when the stored score wins or ties
  assign keep     = slot_r.vld && (slot_r.score >= new_slot.score);
  assign take_new = left_keep && !keep;
  assign slot     = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ins_en) begin
      if (take_new) begin
        slot_nxt = new_slot;
      end else if (!left_keep) begin
        slot_nxt = left_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else begin
      slot_r.vld <= slot_nxt.vld;
    end
    slot_r.score  <= slot_nxt.score;
    slot_r.stamp  <= slot_nxt.stamp;
    slot_r.player <= slot_nxt.player;
  end

endmodule
`default_nettype wire

// ===== sv/top_k_sorted_insert_top.sv =====
`default_nettype none
// Top-K score table: keeps the best TABLE_SIZE entries in descending score order, a new
// entry going after every stored entry of greater or equal score. The result of every
// transfer, insert or read, is registered in the output register, so one item per cycle
// is taken while the output is not stalled. Each cell of the chain compares its own score
// with the incoming one and either holds, loads the new entry or takes its left
// neighbour's entry; a read picks one cell by rank.
module top_k_sorted_insert_top
  import tks_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  slot_t            cells [TABLE_SIZE];
  logic             keep_v [TABLE_SIZE];
  logic             take_v [TABLE_SIZE];
  slot_t            new_slot;
  slot_t            zero_slot;
  logic             in_xfer;
  logic             ins_en;
  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;
  logic [RANK_W-1:0] ins_rank;
  logic             any_take;

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign ins_en    = in_xfer && (in_data.opcode == OP_INSERT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign new_slot.vld    = 1'b1;
  assign new_slot.score  = in_data.new_score;
  assign new_slot.stamp  = in_data.new_time;
  assign new_slot.player = in_data.new_player;
  assign zero_slot       = '0;

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_cell
    tks_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ins_en    (ins_en),
      .new_slot  (new_slot),
      .left_slot ((gi == 0) ? zero_slot : cells[(gi == 0) ? 0 : gi-1]),
      .left_keep ((gi == 0) ? 1'b1 : keep_v[(gi == 0) ? 0 : gi-1]),
      .keep      (keep_v[gi]),
      .take_new  (take_v[gi]),
      .slot      (cells[gi])
    );
  end

  // At most one cell takes the new entry; its index is the rank, or TABLE_SIZE if none does
  always_comb begin
    ins_rank = '0;
    any_take = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (take_v[i]) begin
        ins_rank = ins_rank | RANK_W'(i);
        any_take = 1'b1;
      end
    end
    if (!any_take) begin
      ins_rank = RANK_W'(TABLE_SIZE);
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (in_data.opcode == OP_INSERT) begin
      out_data_nxt.insert_rank = ins_rank;
    end else begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if ((RANK_W'(in_data.read_rank) == RANK_W'(i)) && cells[i].vld) begin
          out_data_nxt.entry_valid  = 1'b1;
          out_data_nxt.entry_score  = cells[i].score;
          out_data_nxt.entry_time   = cells[i].stamp;
          out_data_nxt.entry_player = cells[i].player;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks on the chain contents
  logic vld_gap;
  logic order_bad;
  logic [TABLE_SIZE-1:0] take_bits;
  logic [TABLE_SIZE-1:0] vld_bits;

  always_comb begin
    vld_gap   = 1'b0;
    order_bad = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      take_bits[i] = take_v[i];
      vld_bits[i]  = cells[i].vld;
    end
    for (int i = 1; i < TABLE_SIZE; i++) begin
      if (cells[i].vld && !cells[i-1].vld) begin
        vld_gap = 1'b1;
      end
      if (cells[i].vld && (cells[i].score > cells[i-1].score)) begin
        order_bad = 1'b1;
      end
    end
  end

  a_vld_prefix: assert property (@(posedge clk) disable iff (!rst_n) !vld_gap)
    else $error("valid cells do not form a prefix");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n) !order_bad)
    else $error("cell scores out of descending order");

  a_one_take: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(take_bits))
    else $error("more than one cell takes the new entry");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.opcode == OP_READ)) |=> $stable(vld_bits))
    else $error("read changed the table");

endmodule
`default_nettype wire
